// File: hdl/sftl_pkg.sv
// package for the step function table lookup block
// word types, command codes and control/status structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sftl_pkg;

    localparam int KEY_WIDTH  = 32;
    localparam int PROB_WIDTH = 17;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // 1.0 in Q1.16
    localparam logic [PROB_WIDTH-1:0] PROB_ONE = PROB_WIDTH'(1) << (PROB_WIDTH - 1);

    typedef struct packed {
        logic [1:0]                  cmd;
        logic signed [KEY_WIDTH-1:0] key_value;
        logic                        key_missing;
        logic [PROB_WIDTH-1:0]       prob_value;
    } t_in_word;

    typedef struct packed {
        logic [PROB_WIDTH-1:0] prob_out;
        logic                  result_missing;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic load;
        logic start_search;
        logic step;
        logic emit_missing;
    } t_dp_cmd;

    typedef struct packed {
        logic usable_zero;
        logic last_step;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/sftl_dp.sv
// datapath: key/probability memories, fill counters, search registers, result word
// depends on sftl_pkg; driven by sftl_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sftl_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sftl_pkg::t_in_word i_in,
    input  wire sftl_pkg::t_dp_cmd  i_cmd,
    output sftl_pkg::t_dp_stat      o_stat,
    output logic                    o_valid,
    output sftl_pkg::t_out_word     o_result
);
    import sftl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic signed [KEY_WIDTH-1:0] key_mem  [DEPTH];
    logic [PROB_WIDTH-1:0]       prob_mem [DEPTH];

    logic [CW-1:0] r_entry, n_entry;
    logic [CW-1:0] r_usable, n_usable;
    logic          r_seen, n_seen;
    logic          r_valid, n_valid;

    logic [CW-1:0]               r_first, r_count, r_probe;
    logic signed [KEY_WIDTH-1:0] r_query;
    logic [PROB_WIDTH-1:0]       r_prob;
    logic signed [KEY_WIDTH-1:0] r_rd_key;
    logic [PROB_WIDTH-1:0]       r_rd_prob;
    t_out_word                   r_result;

    logic                  full;
    logic                  wr_en;
    logic [PROB_WIDTH-1:0] wr_prob;
    logic [CW-1:0]         half, nc_taken, nc_not, nf_taken, nc_sel;
    logic [CW-1:0]         addr_taken, addr_not, rd_addr;
    logic                  taken;

    assign full    = (r_entry >= CW'(DEPTH));
    assign wr_en   = i_cmd.load && !full;
    assign wr_prob = (i_in.prob_value > PROB_ONE) ? PROB_ONE : i_in.prob_value;

    // fill bookkeeping; a missing load freezes the usable count
    always_comb begin
        n_entry  = r_entry;
        n_usable = r_usable;
        n_seen   = r_seen;
        if (i_cmd.clear) begin
            n_entry  = '0;
            n_usable = '0;
            n_seen   = 1'b0;
        end else if (i_cmd.load) begin
            n_seen = r_seen | i_in.key_missing;
            if (i_in.key_missing && !r_seen) begin
                n_usable = r_entry;
            end
            if (!full) begin
                n_entry = r_entry + CW'(1);
                if (!n_seen) begin
                    n_usable = r_entry + CW'(1);
                end
            end
        end
    end

    // one probe per cycle: both next probe addresses are formed beside the compare
    always_comb begin
        half       = r_count >> 1;
        taken      = !(r_query < r_rd_key);
        nf_taken   = r_probe + CW'(1);
        nc_taken   = r_count - half - CW'(1);
        nc_not     = half;
        addr_taken = nf_taken + (nc_taken >> 1);
        addr_not   = r_first + (half >> 1);
        nc_sel     = taken ? nc_taken : nc_not;
        if (i_cmd.start_search) begin
            rd_addr = r_usable >> 1;
        end else if (i_cmd.step) begin
            rd_addr = taken ? addr_taken : addr_not;
        end else begin
            rd_addr = r_probe;
        end
    end

    assign n_valid = i_cmd.emit_missing || (i_cmd.step && nc_sel == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= '0;
            r_usable <= '0;
            r_seen   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_entry  <= n_entry;
            r_usable <= n_usable;
            r_seen   <= n_seen;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[r_entry[AW-1:0]]  <= i_in.key_value;
            prob_mem[r_entry[AW-1:0]] <= wr_prob;
        end
        r_rd_key  <= key_mem[rd_addr[AW-1:0]];
        r_rd_prob <= prob_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_search) begin
            r_first <= '0;
            r_count <= r_usable;
            r_probe <= r_usable >> 1;
            r_query <= i_in.key_value;
            r_prob  <= '0;
        end else if (i_cmd.step) begin
            r_count <= nc_sel;
            r_probe <= rd_addr;
            if (taken) begin
                r_first <= nf_taken;
                r_prob  <= r_rd_prob;
            end
        end
        if (i_cmd.emit_missing) begin
            r_result.prob_out       <= '0;
            r_result.result_missing <= 1'b1;
        end else if (i_cmd.step && nc_sel == '0) begin
            r_result.prob_out       <= taken ? r_rd_prob : r_prob;
            r_result.result_missing <= 1'b0;
        end
    end

    assign o_stat.usable_zero = (r_usable == '0);
    assign o_stat.last_step   = (nc_sel == '0);
    assign o_valid            = r_valid;
    assign o_result           = r_result;

    a_usable_le_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_usable <= r_entry)
        else $error("usable count above entry count");

    a_step_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_count != '0)
        else $error("search step with empty range");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_probe < r_usable && r_probe >= r_first))
        else $error("probe outside usable range");

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.result_missing) |-> r_result.prob_out == '0)
        else $error("missing result with nonzero probability");

endmodule

`default_nettype wire

// File: hdl/sftl_ctrl.sv
// controller: decodes commands and sequences the search
// depends on sftl_pkg; commands sftl_dp
`timescale 1ns / 1ps
`default_nettype none

module sftl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire sftl_pkg::t_in_word i_in,
    input  wire sftl_pkg::t_dp_stat i_stat,
    output sftl_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);
    import sftl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.cmd)
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_LOAD:  o_cmd.load  = 1'b1;
                        CMD_QUERY: begin
                            if (i_in.key_missing || i_stat.usable_zero) begin
                                o_cmd.emit_missing = 1'b1;
                            end else begin
                                o_cmd.start_search = 1'b1;
                                n_state            = S_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_stat.last_step) |=> !r_busy)
        else $error("busy held after last probe");

endmodule

`default_nettype wire

// File: hdl/step_function_table_lookup.sv
// top level of the step function table lookup
// depends on sftl_pkg, sftl_ctrl, sftl_dp
//
//  channel   handshake            payload      notes
//  command   start / busy         i_in         taken when start high and busy low
//  result    o_valid (one cycle)  o_result     one word per query, cannot be held off
//
// clear and load leave busy low
// a missing query, or one on an empty table, gives its result the next cycle
// any other query holds busy while it probes the key memory, at most
// clog2(DEPTH+1) probes (11 for 1024 entries); the result strobes with busy falling
// synchronous reset empties the table; the memories themselves are not cleared
`timescale 1ns / 1ps
`default_nettype none

module step_function_table_lookup #(
    parameter int DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire sftl_pkg::t_in_word i_in,
    output logic                    busy,
    output logic                    o_valid,
    output sftl_pkg::t_out_word     o_result
);
    import sftl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sftl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_in    (i_in),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    sftl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
